// ===== src/assert_macros.svh =====
// Assertion macros shared by the one-wire master RTL.
// Included by files that carry concurrent checks; needs a clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OWM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("one-wire master check failed");

// next-cycle implication
`define OWM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("one-wire master check failed");

`endif

// ===== src/owm_pkg.sv =====
// Package for the one-wire master: widths, codes, register map, timing helpers.
// No dependencies; used by every other file of the block except assert_macros.svh.
`timescale 1ns / 1ps

package owm_pkg;

   localparam int TIMER_WIDTH    = 10;
   localparam int TIMER_MAX      = (1 << TIMER_WIDTH) - 1;
   localparam int CFG_WIDTH      = 10;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int BYTE_WIDTH     = 8;
   localparam int BIT_CNT_WIDTH  = 4;

   localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW   = 10'd500;
   localparam logic [CFG_WIDTH-1:0] RST_PRES_SAMPLE = 10'd60;
   localparam logic [CFG_WIDTH-1:0] RST_PRES_REST   = 10'd400;
   localparam logic [CFG_WIDTH-1:0] RST_LONG_PHASE  = 10'd60;
   localparam logic [CFG_WIDTH-1:0] RST_SHORT_PHASE = 10'd5;
   localparam logic [CFG_WIDTH-1:0] RST_READ_LOW    = 10'd1;
   localparam logic [CFG_WIDTH-1:0] RST_READ_WAIT   = 10'd10;
   localparam logic [CFG_WIDTH-1:0] RST_READ_REST   = 10'd40;

   typedef enum logic [1:0] {
      FN_TICK  = 2'd0,
      FN_RESET = 2'd1,
      FN_WRITE = 2'd2,
      FN_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOW  = 2'd1,
      PH_WAIT = 2'd2,
      PH_REST = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      RG_RESET_LOW   = 3'd0,
      RG_PRES_SAMPLE = 3'd1,
      RG_PRES_REST   = 3'd2,
      RG_LONG_PHASE  = 3'd3,
      RG_SHORT_PHASE = 3'd4,
      RG_READ_LOW    = 3'd5,
      RG_READ_WAIT   = 3'd6,
      RG_READ_REST   = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_time;
      logic [CFG_WIDTH-1:0] presence_sample_time;
      logic [CFG_WIDTH-1:0] presence_rest_time;
      logic [CFG_WIDTH-1:0] long_phase_time;
      logic [CFG_WIDTH-1:0] short_phase_time;
      logic [CFG_WIDTH-1:0] read_low_time;
      logic [CFG_WIDTH-1:0] read_wait_time;
      logic [CFG_WIDTH-1:0] read_rest_time;
   } cfg_type;

   typedef struct packed {
      logic                  drive_low;
      logic                  busy_res;
      logic                  done_res;
      logic                  device_present;
      logic [BYTE_WIDTH-1:0] rx_byte;
   } res_type;

   // saturate a tick count to the timer range
   function automatic logic [TIMER_WIDTH-1:0] sat_for(input logic [CFG_WIDTH-1:0] d);
      if (int'(d) > TIMER_MAX) begin
         return TIMER_WIDTH'(TIMER_MAX);
      end
      return TIMER_WIDTH'(d);
   endfunction

   // timer load for a phase of d ticks, at least one
   function automatic logic [TIMER_WIDTH-1:0] load_for(input logic [CFG_WIDTH-1:0] d);
      logic [CFG_WIDTH-1:0] m;
      m = (d == '0) ? '0 : d - CFG_WIDTH'(1);
      return sat_for(m);
   endfunction

   // length of the low phase that opens a slot
   function automatic logic [CFG_WIDTH-1:0] low_len(input func_type op, input logic lsb,
                                                    input cfg_type cfg);
      if (op == FN_RESET) begin
         return cfg.reset_low_time;
      end
      if (op == FN_READ) begin
         return cfg.read_low_time;
      end
      return lsb ? cfg.short_phase_time : cfg.long_phase_time;
   endfunction

endpackage

// ===== src/owm_if.sv =====
// Channel interfaces of the one-wire master: command/tick items in, bus results out.
// Depends on owm_pkg for field widths.
`timescale 1ns / 1ps

interface owm_req_if import owm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [BYTE_WIDTH-1:0] tx_byte;
   logic                  line_level;

   modport source (output valid, func, tx_byte, line_level, input ready);
   modport sink   (input valid, func, tx_byte, line_level, output ready);
endinterface

interface owm_rsp_if import owm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  drive_low;
   logic                  busy_res;
   logic                  done_res;
   logic                  device_present;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, drive_low, busy_res, done_res, device_present, rx_byte,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, device_present, rx_byte,
                   output ready);
endinterface

// ===== src/owm_csr.sv =====
// APB-style timing register file of the one-wire master.
// Depends on owm_pkg for the register map and the cfg_type struct.
`timescale 1ns / 1ps

module owm_csr import owm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type              cfg_ff, cfg_in;
   reg_idx_type          idx;
   logic                 wr_en;
   logic [CFG_WIDTH-1:0] wval;
   logic [CFG_WIDTH-1:0] rval;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wval       = csr_pwdata[CFG_WIDTH-1:0];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      rval   = '0;
      case (idx)
         RG_RESET_LOW: begin
            rval = cfg_ff.reset_low_time;
            if (wr_en) cfg_in.reset_low_time = wval;
         end
         RG_PRES_SAMPLE: begin
            rval = cfg_ff.presence_sample_time;
            if (wr_en) cfg_in.presence_sample_time = wval;
         end
         RG_PRES_REST: begin
            rval = cfg_ff.presence_rest_time;
            if (wr_en) cfg_in.presence_rest_time = wval;
         end
         RG_LONG_PHASE: begin
            rval = cfg_ff.long_phase_time;
            if (wr_en) cfg_in.long_phase_time = wval;
         end
         RG_SHORT_PHASE: begin
            rval = cfg_ff.short_phase_time;
            if (wr_en) cfg_in.short_phase_time = wval;
         end
         RG_READ_LOW: begin
            rval = cfg_ff.read_low_time;
            if (wr_en) cfg_in.read_low_time = wval;
         end
         RG_READ_WAIT: begin
            rval = cfg_ff.read_wait_time;
            if (wr_en) cfg_in.read_wait_time = wval;
         end
         RG_READ_REST: begin
            rval = cfg_ff.read_rest_time;
            if (wr_en) cfg_in.read_rest_time = wval;
         end
         default: begin
            rval = '0;
         end
      endcase
   end

   assign csr_prdata = CSR_DATA_WIDTH'(rval);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time       <= RST_RESET_LOW;
         cfg_ff.presence_sample_time <= RST_PRES_SAMPLE;
         cfg_ff.presence_rest_time   <= RST_PRES_REST;
         cfg_ff.long_phase_time      <= RST_LONG_PHASE;
         cfg_ff.short_phase_time     <= RST_SHORT_PHASE;
         cfg_ff.read_low_time        <= RST_READ_LOW;
         cfg_ff.read_wait_time       <= RST_READ_WAIT;
         cfg_ff.read_rest_time       <= RST_READ_REST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/owm_engine.sv =====
// Slot sequencer of the one-wire master: advances one tick per accepted item.
// Depends on owm_pkg (phase/func codes, timing helpers) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module owm_engine import owm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [BYTE_WIDTH-1:0] tx_byte,
   input  logic                  line_level,
   input  cfg_type               cfg,
   output res_type               res
);

   phase_type                phase_ff, phase_in;
   func_type                 op_ff, op_in;
   logic [TIMER_WIDTH-1:0]   tmr_ff, tmr_in;
   logic [BYTE_WIDTH-1:0]    sr_ff, sr_in;
   logic [BIT_CNT_WIDTH-1:0] bc_ff, bc_in;
   logic                     pf_ff, pf_in;
   logic [BYTE_WIDTH-1:0]    rb_ff, rb_in;

   func_type             fn;
   logic                 fin;
   logic [CFG_WIDTH-1:0] rest;

   assign fn = func_type'(func);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= FN_TICK;
         tmr_ff   <= '0;
         sr_ff    <= '0;
         bc_ff    <= '0;
         pf_ff    <= 1'b0;
         rb_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         tmr_ff   <= tmr_in;
         sr_ff    <= sr_in;
         bc_ff    <= bc_in;
         pf_ff    <= pf_in;
         rb_ff    <= rb_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      tmr_in       = tmr_ff;
      sr_in        = sr_ff;
      bc_in        = bc_ff;
      pf_in        = pf_ff;
      rb_in        = rb_ff;
      fin          = 1'b0;
      rest         = '0;
      res.drive_low = 1'b0;
      res.busy_res  = 1'b0;
      res.done_res  = 1'b0;
      if (accept) begin
         // a command starts on the tick it arrives
         if (phase_in == PH_IDLE && fn != FN_TICK) begin
            op_in    = fn;
            bc_in    = '0;
            sr_in    = (fn == FN_WRITE) ? tx_byte : '0;
            phase_in = PH_LOW;
            tmr_in   = load_for(low_len(fn, sr_in[0], cfg));
         end
         if (phase_in != PH_IDLE) begin
            res.busy_res  = 1'b1;
            res.drive_low = (phase_in == PH_LOW);
            if (tmr_in != '0) begin
               tmr_in = tmr_in - TIMER_WIDTH'(1);
            end else begin
               case (phase_in)
                  PH_LOW: begin
                     if (op_in == FN_WRITE) begin
                        phase_in = PH_REST;
                        tmr_in   = load_for(sr_in[0] ? cfg.long_phase_time
                                                     : cfg.short_phase_time);
                     end else begin
                        phase_in = PH_WAIT;
                        tmr_in   = sat_for((op_in == FN_RESET) ? cfg.presence_sample_time
                                                               : cfg.read_wait_time);
                     end
                  end
                  PH_WAIT: begin
                     if (op_in == FN_RESET) begin
                        pf_in = ~line_level;
                        rest  = cfg.presence_rest_time;
                     end else begin
                        sr_in = {line_level, sr_in[BYTE_WIDTH-1:1]};
                        rest  = cfg.read_rest_time;
                     end
                     if (rest == '0) begin
                        fin = 1'b1;
                     end else begin
                        phase_in = PH_REST;
                        tmr_in   = load_for(rest);
                     end
                  end
                  PH_REST: begin
                     fin = 1'b1;
                  end
                  default: begin
                     fin = 1'b0;
                  end
               endcase
               if (fin) begin
                  if (op_in != FN_RESET) begin
                     bc_in = bc_in + BIT_CNT_WIDTH'(1);
                     if (op_in == FN_WRITE) sr_in = sr_in >> 1;
                  end
                  if (op_in != FN_RESET && !bc_in[BIT_CNT_WIDTH-1]) begin
                     phase_in = PH_LOW;
                     tmr_in   = load_for(low_len(op_in, sr_in[0], cfg));
                  end else begin
                     if (op_in == FN_READ) rb_in = sr_in;
                     phase_in     = PH_IDLE;
                     tmr_in       = '0;
                     res.done_res = 1'b1;
                  end
               end
            end
         end
      end
      res.device_present = pf_in;
      res.rx_byte        = rb_in;
   end

   `OWM_ASSERT_IMP(a_idle_timer_clear, phase_ff == PH_IDLE, tmr_ff == '0)
   `OWM_ASSERT_IMP(a_bit_count_bound, 1'b1, bc_ff <= BIT_CNT_WIDTH'(BYTE_WIDTH))
   `OWM_ASSERT_NXT(a_done_goes_idle, accept && res.done_res, phase_ff == PH_IDLE)
   `OWM_ASSERT_IMP(a_done_is_busy, res.done_res, res.busy_res && accept)

endmodule

// ===== src/one_wire_master_unit.sv =====
// Top level of the one-wire bus master: register file, slot sequencer, result register.
// Depends on owm_pkg, owm_if, owm_csr, owm_engine and assert_macros.svh.
//
//   channel   port                 direction   handshake
//   items     req_ch (owm_req_if)  in          valid/ready
//   results   rsp_ch (owm_rsp_if)  out         valid/ready
//   config    csr_*                in          APB-style, pready tied high
//
// An item is one bus tick giving one result; items are taken each cycle unless stalled.
// The sequencer state and the result register update on the same edge the item is taken.
// Input ready drops only while a result is held and the result side stalls.
// Reset is synchronous; registers return to their default timings, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module one_wire_master_unit import owm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   owm_req_if.sink                   req_ch,
   owm_rsp_if.source                 rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;
   res_type res;
   res_type res_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   owm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   owm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_ch.func),
      .tx_byte    (req_ch.tx_byte),
      .line_level (req_ch.line_level),
      .cfg        (cfg),
      .res        (res)
   );

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive_low      = res_ff.drive_low;
   assign rsp_ch.busy_res       = res_ff.busy_res;
   assign rsp_ch.done_res       = res_ff.done_res;
   assign rsp_ch.device_present = res_ff.device_present;
   assign rsp_ch.rx_byte        = res_ff.rx_byte;

   `OWM_ASSERT_NXT(a_accept_gives_result, accept, rsp_valid_ff)
   `OWM_ASSERT_IMP(a_no_accept_on_stall, rsp_valid_ff && !rsp_ch.ready, !accept)

endmodule
